### sv/fmr_pkg.sv
package fmr_pkg;

	localparam int TIME_BITS_DEF = 64;
	localparam int IN_W = 64;
	localparam int CFG_W = 34;
	localparam int IDX_W = 2;
	localparam int RES_W = 32;
	localparam int MUL_W = 34;
	localparam int CNTX_W = 46;

	localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_STALE_LIMIT = 2'd1;

	localparam logic [CFG_W-1:0] WINDOW_RESET = 34'd250000000;
	localparam logic [CFG_W-1:0] STALE_RESET = 34'd1000000000;

	localparam logic [MUL_W-1:0] FPS_NUM = 34'd10000000000;
	localparam logic [13:0] TIME_DIV = 14'd10000;
	localparam logic [RES_W-1:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/fmr_div.sv
module fmr_div #(
	parameter int TIME_BITS = fmr_pkg::TIME_BITS_DEF,
	parameter int DW = (TIME_BITS > fmr_pkg::CNTX_W) ? TIME_BITS : fmr_pkg::CNTX_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TIME_BITS-1:0]          a,
	input  logic [fmr_pkg::MUL_W-1:0]     b,
	input  logic [DW-1:0]                 d,
	output logic [fmr_pkg::RES_W-1:0]     result,
	output fmr_pkg::div_stat_t            stat
);
	import fmr_pkg::*;

	localparam int NUM_W = TIME_BITS + MUL_W;
	localparam int SW = $clog2(NUM_W + 1);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_DIV  = 4'b0100,
		D_RND  = 4'b1000
	} dstate_t;

	dstate_t phase_q;
	logic [SW-1:0] step_q;
	logic [TIME_BITS-1:0] a_q;
	logic [MUL_W-1:0] b_q;
	logic [DW-1:0] d_q;
	logic [NUM_W-1:0] prod_q;
	logic [DW-1:0] rem_q;
	logic [RES_W:0] q_q;
	logic ovf_q;
	logic [RES_W-1:0] res_q;
	logic done_q;

	logic [NUM_W-1:0] addend;
	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic take;
	logic half;
	logic [RES_W:0] rounded;

	always_comb begin
		addend = b_q[MUL_W-1] ? NUM_W'(a_q) : '0;
		shifted = {rem_q, prod_q[NUM_W-1]};
		diff = shifted - {1'b0, d_q};
		take = shifted >= {1'b0, d_q};
		half = {rem_q, 1'b0} >= {1'b0, d_q};
		rounded = {1'b0, q_q[RES_W-1:0]} + (RES_W+1)'(half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= D_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (phase_q == D_RND);
			case (phase_q)
				D_IDLE: begin
					if (start) begin
						phase_q <= D_MUL;
						step_q <= '0;
					end
				end
				D_MUL: begin
					if (step_q == SW'(MUL_W - 1)) begin
						phase_q <= D_DIV;
						step_q <= '0;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				D_DIV: begin
					if (step_q == SW'(NUM_W - 1)) begin
						phase_q <= D_RND;
						step_q <= '0;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				D_RND: begin
					phase_q <= D_IDLE;
				end
				default: begin
					phase_q <= D_IDLE;
				end
			endcase
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		case (phase_q)
			D_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					d_q <= d;
					prod_q <= '0;
					rem_q <= '0;
					q_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			D_MUL: begin
				prod_q <= {prod_q[NUM_W-2:0], 1'b0} + addend;
				b_q <= {b_q[MUL_W-2:0], 1'b0};
			end
			D_DIV: begin
				prod_q <= {prod_q[NUM_W-2:0], 1'b0};
				if (take) begin
					rem_q <= diff[DW-1:0];
				end else begin
					rem_q <= shifted[DW-1:0];
				end
				q_q <= {q_q[RES_W-1:0], take};
				ovf_q <= ovf_q | q_q[RES_W];
			end
			D_RND: begin
				if (d_q == '0) begin
					res_q <= '0;
				end else if (ovf_q || q_q[RES_W] || rounded[RES_W]) begin
					res_q <= SAT32;
				end else begin
					res_q <= rounded[RES_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;
	assign stat.busy = (phase_q != D_IDLE);
	assign stat.done = done_q;

endmodule

### sv/frame_rate_meter.sv
// frame rate meter
// s_* carries one request: tuser is the kind (0 frame, 1 display refresh), tdata the
// time in ns, of which the low TIME_BITS bits are used and zero means unset.
// m_* returns one result per request with six 32-bit values packed in tdata.
// cfg_* writes window_length_ns (index 0) or stale_limit_ns (index 1); it is
// always ready and is meant to be used while the block is idle.
// a refresh, or a frame that updates neither the gap nor the window values, goes
// from evaluation straight to the done state. a frame runs up to four rounded
// divisions on one shared shift/subtract unit, each with a start, 34 multiply steps,
// TIME_BITS+34 divide steps, a rounding step and a done strobe: four when the frame
// updates both the gap and the window values, two when it updates only one of them.
// s_tready is high only while the block is idle, so no request is taken until the
// last one reaches the done state; a finished result sits in the output register,
// so the next request is taken while that result waits.
// when the receiver stalls, the next result waits inside until the output frees.
// reset clears all stores to zero and loads the default register values.
module frame_rate_meter #(
	parameter int TIME_BITS = fmr_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fmr_pkg::IN_W-1:0]      s_tdata,   // event time in ns
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// shown_fps_tenths, display_time_hundredths, window_fps_tenths,
	// window_time_hundredths, interval_fps_tenths, interval_time_hundredths
	output logic [6*fmr_pkg::RES_W-1:0]   m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fmr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fmr_pkg::CFG_W-1:0]     cfg_data
);
	import fmr_pkg::*;

	localparam int DW = (TIME_BITS > CNTX_W) ? TIME_BITS : CNTX_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_OPS  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		OP_IFPS  = 2'd0,
		OP_ITIME = 2'd1,
		OP_AFPS  = 2'd2,
		OP_ATIME = 2'd3
	} op_t;

	state_t state_q;
	op_t op_q;
	logic start_q;
	logic do_avg_q;

	logic [CFG_W-1:0] wlen_q;
	logic [CFG_W-1:0] stale_q;

	logic [TIME_BITS-1:0] now_q;
	logic kind_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0] wstart_q;
	logic [RES_W-1:0] wcnt_q;
	logic [RES_W-1:0] avg_fps_q;
	logic [RES_W-1:0] avg_time_q;
	logic [RES_W-1:0] inst_fps_q;
	logic [RES_W-1:0] inst_time_q;
	logic [RES_W-1:0] shown_fps_q;
	logic [RES_W-1:0] shown_time_q;

	logic [TIME_BITS-1:0] gap_q;
	logic [TIME_BITS-1:0] elap_q;
	logic [RES_W-1:0] cntw_q;
	logic [CNTX_W-1:0] cntx_q;

	logic m_tvalid_q;
	logic [6*RES_W-1:0] m_tdata_q;

	logic [TIME_BITS-1:0] start_eff;
	logic [RES_W-1:0] cnt_eff;
	logic do_inst;
	logic [TIME_BITS-1:0] gap;
	logic [TIME_BITS-1:0] elapsed;
	logic close_win;
	logic avg_ok;
	logic [TIME_BITS-1:0] age;
	logic fresh;
	logic out_free;
	logic start_d;

	logic [TIME_BITS-1:0] div_a;
	logic [MUL_W-1:0] div_b;
	logic [DW-1:0] div_d;
	logic [RES_W-1:0] div_res;
	div_stat_t div_stat;

	always_comb begin
		start_eff = (wstart_q == '0) ? now_q : wstart_q;
		cnt_eff = ((wstart_q == '0) ? '0 : wcnt_q) + RES_W'(1);
		do_inst = (prev_q != '0) && (now_q > prev_q);
		gap = now_q - prev_q;
		elapsed = now_q - start_eff;
		close_win = elapsed >= TIME_BITS'(wlen_q);
		avg_ok = (elapsed != '0) && (cnt_eff != '0);
		age = now_q - wstart_q;
		fresh = (wstart_q != '0) && (age <= TIME_BITS'(stale_q)) && (avg_fps_q != '0);
		out_free = !m_tvalid_q || m_tready;
	end

	// divider start for the next operation
	always_comb begin
		start_d = 1'b0;
		case (state_q)
			ST_EVAL: begin
				start_d = !kind_q && (do_inst || (close_win && avg_ok));
			end
			ST_OPS: begin
				if (div_stat.done) begin
					start_d = (op_q == OP_IFPS) || (op_q == OP_AFPS) ||
						((op_q == OP_ITIME) && do_avg_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_IFPS: begin
				div_a = TIME_BITS'(1);
				div_b = FPS_NUM;
				div_d = DW'(gap_q);
			end
			OP_ITIME: begin
				div_a = gap_q;
				div_b = MUL_W'(1);
				div_d = DW'(TIME_DIV);
			end
			OP_AFPS: begin
				div_a = TIME_BITS'(cntw_q);
				div_b = FPS_NUM;
				div_d = DW'(elap_q);
			end
			OP_ATIME: begin
				div_a = elap_q;
				div_b = MUL_W'(1);
				div_d = DW'(cntx_q);
			end
			default: begin
				div_a = '0;
				div_b = '0;
				div_d = '0;
			end
		endcase
	end

	fmr_div #(
		.TIME_BITS(TIME_BITS),
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.a(div_a),
		.b(div_b),
		.d(div_d),
		.result(div_res),
		.stat(div_stat)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WINDOW_RESET;
			stale_q <= STALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: wlen_q <= cfg_data;
				REG_STALE_LIMIT: stale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_IFPS;
			start_q <= 1'b0;
			do_avg_q <= 1'b0;
			prev_q <= '0;
			wstart_q <= '0;
			wcnt_q <= '0;
			avg_fps_q <= '0;
			avg_time_q <= '0;
			inst_fps_q <= '0;
			inst_time_q <= '0;
			shown_fps_q <= '0;
			shown_time_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= start_d;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!kind_q) begin
						prev_q <= now_q;
						do_avg_q <= close_win && avg_ok;
						if (close_win) begin
							wstart_q <= now_q;
							wcnt_q <= '0;
							if (!avg_ok) begin
								avg_fps_q <= '0;
								avg_time_q <= '0;
							end
						end else begin
							wstart_q <= start_eff;
							wcnt_q <= cnt_eff;
						end
						if (do_inst) begin
							op_q <= OP_IFPS;
							state_q <= ST_OPS;
						end else if (close_win && avg_ok) begin
							op_q <= OP_AFPS;
							state_q <= ST_OPS;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						shown_fps_q <= fresh ? avg_fps_q : '0;
						shown_time_q <= fresh ? avg_time_q : '0;
						state_q <= ST_DONE;
					end
				end
				ST_OPS: begin
					if (div_stat.done) begin
						case (op_q)
							OP_IFPS: begin
								inst_fps_q <= div_res;
								op_q <= OP_ITIME;
							end
							OP_ITIME: begin
								inst_time_q <= div_res;
								if (do_avg_q) begin
									op_q <= OP_AFPS;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_AFPS: begin
								avg_fps_q <= div_res;
								op_q <= OP_ATIME;
							end
							OP_ATIME: begin
								avg_time_q <= div_res;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, operands and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			now_q <= s_tdata[TIME_BITS-1:0];
			kind_q <= s_tuser;
		end
		if (state_q == ST_EVAL) begin
			gap_q <= gap;
			elap_q <= elapsed;
			cntw_q <= cnt_eff;
		end
		cntx_q <= CNTX_W'(cntw_q) * CNTX_W'(TIME_DIV);
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {
				(inst_time_q != '0) ? inst_time_q : avg_time_q,
				(inst_fps_q != '0) ? inst_fps_q : avg_fps_q,
				avg_time_q,
				avg_fps_q,
				shown_time_q,
				shown_fps_q
			};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign cfg_ready = 1'b1;

	a_no_request_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_stat.busy)
		else $error("request taken while divider busy");

	a_start_only_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !div_stat.busy && state_q == ST_OPS)
		else $error("divider started while busy");

	a_done_in_ops: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_OPS)
		else $error("divider result with no operation pending");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EVAL)
		else $error("request not evaluated");

endmodule

### sim/tb_frame_rate_meter.sv
`timescale 1ns / 1ps

module tb_frame_rate_meter;
	import fmr_pkg::*;

	typedef enum bit {
		KIND_FRAME   = 1'b0,
		KIND_REFRESH = 1'b1
	} event_kind_t;

	localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

	// lowest field last
	typedef struct packed {
		logic [RES_W-1:0] interval_time_hundredths;
		logic [RES_W-1:0] interval_fps_tenths;
		logic [RES_W-1:0] window_time_hundredths;
		logic [RES_W-1:0] window_fps_tenths;
		logic [RES_W-1:0] display_time_hundredths;
		logic [RES_W-1:0] shown_fps_tenths;
	} rates_t;

	class fps_ledger;
		logic [CFG_W-1:0] win_len = WINDOW_RESET;
		logic [CFG_W-1:0] stale_max = STALE_RESET;
		logic [63:0] last_frame_ns = '0;
		logic [63:0] win_open_ns = '0;
		logic [31:0] win_frames = '0;
		logic [31:0] avg_fps = '0;
		logic [31:0] avg_ms100 = '0;
		logic [31:0] gap_fps = '0;
		logic [31:0] gap_ms100 = '0;
		logic [31:0] shown_fps = '0;
		logic [31:0] shown_ms100 = '0;
		rates_t expected_rates[$];
		int failures = 0;
		int frames = 0;
		int refreshes = 0;
		int compared = 0;
		int windows_closed = 0;
		int reg_writes = 0;

		// half-up rounded quotient, clipped to 32 bits, zero for a zero divisor
		function logic [31:0] rounded_quotient(logic [127:0] num, logic [63:0] den);
			logic [127:0] quo;
			logic [127:0] rem;
			logic [127:0] wide_den;
			if (den == 0)
				return '0;
			wide_den = 128'(den);
			quo = num / wide_den;
			rem = num % wide_den;
			if (quo > 128'(SAT32))
				return SAT32;
			if (rem >= wide_den - rem)
				quo = quo + 128'(1);
			if (quo > 128'(SAT32))
				return SAT32;
			return quo[31:0];
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			reg_writes++;
			if (idx == REG_WINDOW_LENGTH)
				win_len = val;
			else if (idx == REG_STALE_LIMIT)
				stale_max = val;
		endfunction

		function void note_event(event_kind_t kind, logic [63:0] now);
			logic [63:0] gap;
			logic [63:0] elapsed;
			logic [63:0] age;
			logic [63:0] frame_div;
			logic [127:0] frame_num;
			rates_t r;
			if (kind == KIND_FRAME) begin
				frames++;
				if (win_open_ns == 0) begin
					win_open_ns = now;
					win_frames = '0;
				end
				if (last_frame_ns != 0 && now > last_frame_ns) begin
					gap = now - last_frame_ns;
					gap_fps = rounded_quotient(128'(FPS_NUM), gap);
					gap_ms100 = rounded_quotient(128'(gap), 64'(TIME_DIV));
				end
				last_frame_ns = now;
				win_frames = win_frames + 32'd1;
				elapsed = now - win_open_ns;
				if (elapsed >= 64'(win_len)) begin
					windows_closed++;
					if (elapsed != 0 && win_frames != 0) begin
						frame_num = 128'(win_frames);
						frame_num = frame_num * 128'(FPS_NUM);
						frame_div = 64'(win_frames);
						frame_div = frame_div * 64'(TIME_DIV);
						avg_fps = rounded_quotient(frame_num, elapsed);
						avg_ms100 = rounded_quotient(128'(elapsed), frame_div);
					end else begin
						avg_fps = '0;
						avg_ms100 = '0;
					end
					win_open_ns = now;
					win_frames = '0;
				end
			end else begin
				refreshes++;
				age = now - win_open_ns;
				if (win_open_ns != 0 && age <= 64'(stale_max) && avg_fps != 0) begin
					shown_fps = avg_fps;
					shown_ms100 = avg_ms100;
				end else begin
					shown_fps = '0;
					shown_ms100 = '0;
				end
			end
			r.shown_fps_tenths = shown_fps;
			r.display_time_hundredths = shown_ms100;
			r.window_fps_tenths = avg_fps;
			r.window_time_hundredths = avg_ms100;
			r.interval_fps_tenths = (gap_fps != 0) ? gap_fps : avg_fps;
			r.interval_time_hundredths = (gap_ms100 != 0) ? gap_ms100 : avg_ms100;
			expected_rates.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [6*RES_W-1:0] data);
			rates_t got;
			rates_t want;
			got = data;
			if (expected_rates.size() == 0) begin
				$error("result with no request outstanding: %h", data);
				failures++;
				return;
			end
			want = expected_rates.pop_front();
			compared++;
			compare("shown_fps_tenths", want.shown_fps_tenths, got.shown_fps_tenths);
			compare("display_time_hundredths", want.display_time_hundredths,
				got.display_time_hundredths);
			compare("window_fps_tenths", want.window_fps_tenths, got.window_fps_tenths);
			compare("window_time_hundredths", want.window_time_hundredths,
				got.window_time_hundredths);
			compare("interval_fps_tenths", want.interval_fps_tenths, got.interval_fps_tenths);
			compare("interval_time_hundredths", want.interval_time_hundredths,
				got.interval_time_hundredths);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [6*RES_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	fps_ledger ledger = new();
	logic [63:0] now_ns = '0;
	int burst_left = 0;
	int ready_period = 1;
	int ready_duty = 1;
	int ready_hold = 0;
	int ready_tick = 0;

	frame_rate_meter uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// receiver: duty pattern that is picked anew whenever its hold count runs out
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_hold = $urandom_range(50, 600);
			case ($urandom_range(0, 2))
				0: begin
					ready_period = 1;
					ready_duty = 1;
				end
				1: begin
					ready_period = $urandom_range(2, 8);
					ready_duty = $urandom_range(1, ready_period - 1);
				end
				default: begin
					ready_period = $urandom_range(20, 60);
					ready_duty = $urandom_range(1, 5);
				end
			endcase
		end
		ready_hold--;
		ready_tick++;
		m_tready <= (ready_tick % ready_period) < ready_duty;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_result(m_tdata);
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(idx, val);
	endtask

	task automatic program_regs(logic [CFG_W-1:0] win, logic [CFG_W-1:0] stale, bit spare);
		if (spare)
			write_reg(REG_SPARE_HI, {2'($urandom_range(0, 3)), $urandom});
		write_reg(REG_WINDOW_LENGTH, win);
		if (spare)
			write_reg(REG_SPARE_LO, {2'($urandom_range(0, 3)), $urandom});
		write_reg(REG_STALE_LIMIT, stale);
		cfg_valid <= 1'b0;
	endtask

	// one request, with sender bursts and gaps
	task automatic issue(event_kind_t kind, logic [63:0] stamp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= stamp;
		do @(posedge clk); while (!s_tready);
		ledger.note_event(kind, stamp);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (ledger.expected_rates.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] frame_gap(int unsigned scale);
		int unsigned pick;
		logic [63:0] g;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			g = 64'(scale / 2 + $urandom_range(0, scale));
		else if (pick < 82)
			g = 64'($urandom_range(1, 20000));
		else if (pick < 88)
			g = 64'd10000 * 64'($urandom_range(0, 50000)) + 64'd5000;
		else
			g = {$urandom_range(0, 3), $urandom};
		return g;
	endfunction

	task automatic run_traffic(int count, int unsigned scale);
		int unsigned pick;
		logic [63:0] stamp;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				now_ns = now_ns + frame_gap(scale);
				issue(KIND_FRAME, now_ns);
			end else if (pick < 88) begin
				case ($urandom_range(0, 3))
					0: stamp = now_ns;
					1, 2: stamp = now_ns + 64'($urandom_range(0, scale));
					default: stamp = now_ns + {$urandom_range(0, 3), $urandom};
				endcase
				issue(KIND_REFRESH, stamp);
			end else begin
				// noise: arbitrary, unset, repeated, backwards and jumping times
				case ($urandom_range(0, 4))
					0: issue(event_kind_t'($urandom_range(0, 1)), {$urandom, $urandom});
					1: issue(event_kind_t'($urandom_range(0, 1)), 64'd0);
					2: issue(KIND_FRAME, now_ns);
					3: issue(KIND_FRAME, now_ns - 64'($urandom_range(1, scale)));
					default: begin
						now_ns = {$urandom, $urandom};
						issue(KIND_FRAME, now_ns);
					end
				endcase
			end
		end
	endtask

	initial begin
		#25ms;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: unset times, non-increasing times, rounding, clipping
		issue(KIND_REFRESH, 64'd0);
		issue(KIND_FRAME, 64'd0);
		issue(KIND_FRAME, 64'd1000);
		issue(KIND_FRAME, 64'd1000);
		issue(KIND_FRAME, 64'd500);
		issue(KIND_REFRESH, 64'd600);
		issue(KIND_FRAME, 64'd16_667_167);
		issue(KIND_FRAME, 64'd16_672_167);
		issue(KIND_FRAME, 64'd16_677_166);
		issue(KIND_FRAME, 64'd16_677_167);
		issue(KIND_FRAME, 64'd300_000_500);
		issue(KIND_REFRESH, 64'd300_000_500);
		issue(KIND_REFRESH, 64'd1_300_000_500);
		issue(KIND_REFRESH, 64'd1_300_000_501);
		issue(KIND_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(KIND_FRAME, 64'd1);
		issue(KIND_REFRESH, 64'd0);
		issue(KIND_FRAME, 64'd0);
		issue(KIND_FRAME, 64'h8000_0000_0000_0000);
		issue(KIND_FRAME, 64'h8000_0003_FFFF_FFFF);
		issue(KIND_REFRESH, 64'h5555_5555_5555_5555);
		issue(KIND_REFRESH, 64'hAAAA_AAAA_AAAA_AAAA);
		drain();

		now_ns = 64'd1_000_000;
		program_regs(34'd1, 34'd0, 1'b1);
		run_traffic(200, 16_666_667);
		drain();
		program_regs(CFG_MAX, CFG_MAX, 1'b0);
		run_traffic(200, 100_000_000);
		drain();
		program_regs(WINDOW_RESET, STALE_RESET, 1'b1);
		run_traffic(200, 16_666_667);
		drain();
		repeat (5) begin
			program_regs(CFG_W'($urandom_range(1, 600_000_000)),
				CFG_W'($urandom_range(0, 2_000_000_000)), 1'($urandom_range(0, 1)));
			run_traffic(200, $urandom_range(100_000, 40_000_000));
			drain();
		end

		repeat (600) @(posedge clk);
		if (ledger.expected_rates.size() != 0) begin
			$error("%0d results never arrived", ledger.expected_rates.size());
			ledger.failures++;
		end
		$display("covered %0d frame and %0d refresh requests, %0d window closes, %0d reg writes",
			ledger.frames, ledger.refreshes, ledger.windows_closed, ledger.reg_writes);
		$display("%0d results compared, %0d mismatches", ledger.compared, ledger.failures);
		if (ledger.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
